// ----- src/sms_udh_element_parser_macros.svh -----
// Assertion macros used by the checker file sudh_checker.sv.
`ifndef SMS_UDH_ELEMENT_PARSER_MACROS_SVH
`define SMS_UDH_ELEMENT_PARSER_MACROS_SVH

// Same-cycle implication under synchronous reset.
`define SUDH_ASSERT_SAME(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("sudh same-cycle check failed");

// Next-cycle implication under synchronous reset.
`define SUDH_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("sudh next-cycle check failed");

`endif

// ----- src/sudh_pkg.sv -----
package sudh_pkg;

  typedef enum logic [2:0] {
    KIND_SPECIAL = 3'd0,
    KIND_MISC    = 3'd1,
    KIND_EMPTY   = 3'd2,
    KIND_CONCAT  = 3'd3,
    KIND_PORT    = 3'd4,
    KIND_LANG    = 3'd5
  } kind_t;

  typedef struct packed {
    kind_t       kind;
    logic [7:0]  id;
    logic [15:0] val_a;
    logic [15:0] val_b;
    logic        elem_end;
  } elem_t;

  typedef struct packed {
    logic        concat_ok;
    logic        concat_wide;
    logic [15:0] concat_ref;
    logic [7:0]  concat_total;
    logic [7:0]  concat_seq;
    logic        port_ok;
    logic        port_wide;
    logic [15:0] dest_port;
    logic [15:0] orig_port;
    logic [7:0]  single_shift;
    logic [7:0]  locking_shift;
    logic        trunc;
  } summary_t;

  typedef struct packed {
    logic     elem_valid;
    elem_t    elem;
    logic     sum_valid;
    summary_t summ;
  } bundle_t;

  typedef struct packed {
    kind_t       kind;
    logic [7:0]  id;
    logic [15:0] val_a;
    logic [15:0] val_b;
    logic [7:0]  val_c;
    logic        present;
    logic        wide;
    logic        elem_end;
    logic        trunc;
    logic        last;
  } beat_t;

endpackage

// ----- src/sudh_core.sv -----
module sudh_core
  import sudh_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       accept,
  input  logic [7:0] hdr_byte,
  input  logic       hdr_last,
  output bundle_t    bundle
);

  localparam logic [7:0] ID_CONCAT8  = 8'h00;
  localparam logic [7:0] ID_SPECIAL  = 8'h01;
  localparam logic [7:0] ID_PORT8    = 8'h04;
  localparam logic [7:0] ID_PORT16   = 8'h05;
  localparam logic [7:0] ID_CONCAT16 = 8'h08;
  localparam logic [7:0] ID_SSHIFT   = 8'h24;
  localparam logic [7:0] ID_LSHIFT   = 8'h25;

  typedef enum logic [1:0] {
    PH_ID    = 2'd0,
    PH_LEN   = 2'd1,
    PH_FIXED = 2'd2,
    PH_MISC  = 2'd3
  } phase_t;

  function automatic logic [2:0] fixed_count(input logic [7:0] id);
    case (id)
      ID_CONCAT8:  fixed_count = 3'd3;
      ID_CONCAT16: fixed_count = 3'd4;
      ID_PORT8:    fixed_count = 3'd2;
      ID_PORT16:   fixed_count = 3'd4;
      ID_SPECIAL:  fixed_count = 3'd2;
      ID_SSHIFT:   fixed_count = 3'd1;
      ID_LSHIFT:   fixed_count = 3'd1;
      default:     fixed_count = 3'd0;
    endcase
  endfunction

  phase_t      phase, phase_next;
  logic [7:0]  current_id, current_id_next;
  logic [7:0]  bytes_left, bytes_left_next;
  logic [7:0]  byte_index, byte_index_next;
  logic [15:0] scratch_first, scratch_first_next;
  logic [15:0] scratch_second, scratch_second_next;
  logic [7:0]  scratch_third, scratch_third_next;
  logic        concat_ok, concat_ok_next;
  logic        concat_wide, concat_wide_next;
  logic [15:0] concat_ref, concat_ref_next;
  logic [7:0]  concat_total, concat_total_next;
  logic [7:0]  concat_seq, concat_seq_next;
  logic        port_ok, port_ok_next;
  logic        port_wide, port_wide_next;
  logic [15:0] dest_port, dest_port_next;
  logic [15:0] orig_port, orig_port_next;
  logic [7:0]  single_shift, single_shift_next;
  logic [7:0]  locking_shift, locking_shift_next;

  logic [2:0]  fc;
  logic [7:0]  left_dec;
  logic        concat_good;

  always_comb begin
    phase_next          = phase;
    current_id_next     = current_id;
    bytes_left_next     = bytes_left;
    byte_index_next     = byte_index;
    scratch_first_next  = scratch_first;
    scratch_second_next = scratch_second;
    scratch_third_next  = scratch_third;
    concat_ok_next      = concat_ok;
    concat_wide_next    = concat_wide;
    concat_ref_next     = concat_ref;
    concat_total_next   = concat_total;
    concat_seq_next     = concat_seq;
    port_ok_next        = port_ok;
    port_wide_next      = port_wide;
    dest_port_next      = dest_port;
    orig_port_next      = orig_port;
    single_shift_next   = single_shift;
    locking_shift_next  = locking_shift;

    bundle = '0;
    fc = fixed_count(current_id);
    left_dec = bytes_left - 8'd1;
    concat_good = (scratch_second != 16'd0) && (hdr_byte != 8'd0) &&
                  ({8'd0, hdr_byte} <= scratch_second);

    case (phase)
      PH_ID: begin
        current_id_next = hdr_byte;
        phase_next      = PH_LEN;
      end
      PH_LEN: begin
        byte_index_next     = 8'd0;
        scratch_first_next  = 16'd0;
        scratch_second_next = 16'd0;
        scratch_third_next  = 8'd0;
        if (fc != 3'd0) begin
          bytes_left_next = {5'd0, fc};
          phase_next      = PH_FIXED;
        end else if (hdr_byte == 8'd0) begin
          bundle.elem_valid = 1'b1;
          bundle.elem.kind  = KIND_EMPTY;
          bundle.elem.id    = current_id;
          phase_next        = PH_ID;
        end else begin
          bytes_left_next = hdr_byte;
          phase_next      = PH_MISC;
        end
      end
      PH_FIXED: begin
        case (current_id)
          ID_CONCAT8: begin
            if (byte_index == 8'd0) begin
              scratch_first_next = {8'd0, hdr_byte};
            end else if (byte_index == 8'd1) begin
              scratch_second_next = {8'd0, hdr_byte};
            end else begin
              scratch_third_next = hdr_byte;
              if (concat_good) begin
                concat_ok_next    = 1'b1;
                concat_wide_next  = 1'b0;
                concat_ref_next   = scratch_first;
                concat_total_next = scratch_second[7:0];
                concat_seq_next   = hdr_byte;
              end
            end
          end
          ID_CONCAT16: begin
            if (byte_index == 8'd0) begin
              scratch_first_next = {hdr_byte, 8'd0};
            end else if (byte_index == 8'd1) begin
              scratch_first_next = scratch_first | {8'd0, hdr_byte};
            end else if (byte_index == 8'd2) begin
              scratch_second_next = {8'd0, hdr_byte};
            end else begin
              scratch_third_next = hdr_byte;
              if (concat_good) begin
                concat_ok_next    = 1'b1;
                concat_wide_next  = 1'b1;
                concat_ref_next   = scratch_first;
                concat_total_next = scratch_second[7:0];
                concat_seq_next   = hdr_byte;
              end
            end
          end
          ID_PORT8: begin
            if (byte_index == 8'd0) begin
              scratch_first_next = {8'd0, hdr_byte};
            end else begin
              port_ok_next   = 1'b1;
              port_wide_next = 1'b0;
              dest_port_next = {8'd0, scratch_first[7:0]};
              orig_port_next = {8'd0, hdr_byte};
            end
          end
          ID_PORT16: begin
            if (byte_index == 8'd0) begin
              scratch_first_next = {hdr_byte, 8'd0};
            end else if (byte_index == 8'd1) begin
              scratch_first_next = scratch_first | {8'd0, hdr_byte};
            end else if (byte_index == 8'd2) begin
              scratch_second_next = {hdr_byte, 8'd0};
            end else begin
              port_ok_next   = 1'b1;
              port_wide_next = 1'b1;
              dest_port_next = scratch_first;
              orig_port_next = scratch_second | {8'd0, hdr_byte};
            end
          end
          ID_SPECIAL: begin
            if (byte_index == 8'd0) begin
              scratch_first_next = {8'd0, hdr_byte};
            end else begin
              bundle.elem_valid = 1'b1;
              bundle.elem.kind  = KIND_SPECIAL;
              bundle.elem.id    = current_id;
              bundle.elem.val_a = scratch_first;
              bundle.elem.val_b = {8'd0, hdr_byte};
            end
          end
          ID_SSHIFT: begin
            single_shift_next = hdr_byte;
          end
          default: begin
            locking_shift_next = hdr_byte;
          end
        endcase
        byte_index_next = byte_index + 8'd1;
        bytes_left_next = left_dec;
        if (left_dec == 8'd0) phase_next = PH_ID;
      end
      default: begin
        bundle.elem_valid    = 1'b1;
        bundle.elem.kind     = KIND_MISC;
        bundle.elem.id       = current_id;
        bundle.elem.val_a    = {8'd0, hdr_byte};
        bundle.elem.val_b    = {8'd0, byte_index};
        bundle.elem.elem_end = (left_dec == 8'd0);
        byte_index_next      = byte_index + 8'd1;
        bytes_left_next      = left_dec;
        if (left_dec == 8'd0) phase_next = PH_ID;
      end
    endcase

    if (hdr_last) begin
      bundle.sum_valid          = 1'b1;
      bundle.summ.concat_ok     = concat_ok_next;
      bundle.summ.concat_wide   = concat_wide_next;
      bundle.summ.concat_ref    = concat_ref_next;
      bundle.summ.concat_total  = concat_total_next;
      bundle.summ.concat_seq    = concat_seq_next;
      bundle.summ.port_ok       = port_ok_next;
      bundle.summ.port_wide     = port_wide_next;
      bundle.summ.dest_port     = dest_port_next;
      bundle.summ.orig_port     = orig_port_next;
      bundle.summ.single_shift  = single_shift_next;
      bundle.summ.locking_shift = locking_shift_next;
      bundle.summ.trunc         = (phase_next != PH_ID);

      phase_next          = PH_ID;
      current_id_next     = 8'd0;
      bytes_left_next     = 8'd0;
      byte_index_next     = 8'd0;
      scratch_first_next  = 16'd0;
      scratch_second_next = 16'd0;
      scratch_third_next  = 8'd0;
      concat_ok_next      = 1'b0;
      concat_wide_next    = 1'b0;
      concat_ref_next     = 16'd0;
      concat_total_next   = 8'd0;
      concat_seq_next     = 8'd0;
      port_ok_next        = 1'b0;
      port_wide_next      = 1'b0;
      dest_port_next      = 16'd0;
      orig_port_next      = 16'd0;
      single_shift_next   = 8'd0;
      locking_shift_next  = 8'd0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase          <= PH_ID;
      current_id     <= 8'd0;
      bytes_left     <= 8'd0;
      byte_index     <= 8'd0;
      scratch_first  <= 16'd0;
      scratch_second <= 16'd0;
      scratch_third  <= 8'd0;
      concat_ok      <= 1'b0;
      concat_wide    <= 1'b0;
      concat_ref     <= 16'd0;
      concat_total   <= 8'd0;
      concat_seq     <= 8'd0;
      port_ok        <= 1'b0;
      port_wide      <= 1'b0;
      dest_port      <= 16'd0;
      orig_port      <= 16'd0;
      single_shift   <= 8'd0;
      locking_shift  <= 8'd0;
    end else if (accept) begin
      phase          <= phase_next;
      current_id     <= current_id_next;
      bytes_left     <= bytes_left_next;
      byte_index     <= byte_index_next;
      scratch_first  <= scratch_first_next;
      scratch_second <= scratch_second_next;
      scratch_third  <= scratch_third_next;
      concat_ok      <= concat_ok_next;
      concat_wide    <= concat_wide_next;
      concat_ref     <= concat_ref_next;
      concat_total   <= concat_total_next;
      concat_seq     <= concat_seq_next;
      port_ok        <= port_ok_next;
      port_wide      <= port_wide_next;
      dest_port      <= dest_port_next;
      orig_port      <= orig_port_next;
      single_shift   <= single_shift_next;
      locking_shift  <= locking_shift_next;
    end
  end

endmodule

// ----- src/sudh_emit.sv -----
module sudh_emit
  import sudh_pkg::*;
(
  input  logic    clk,
  input  logic    rst,
  input  logic    accept,
  input  bundle_t bundle,
  output logic    in_ready,
  output logic    out_valid,
  input  logic    out_ready,
  output beat_t   beat
);

  typedef enum logic [1:0] {
    SEL_CONCAT = 2'd0,
    SEL_PORT   = 2'd1,
    SEL_LANG   = 2'd2
  } sel_t;

  logic     elem_pend;
  logic     sum_pend;
  sel_t     sum_sel;
  elem_t    elem;
  summary_t summ;
  logic     final_beat;
  logic     fire;

  assign out_valid  = elem_pend | sum_pend;
  assign final_beat = (elem_pend & ~sum_pend) |
                      (~elem_pend & sum_pend & (sum_sel == SEL_LANG));
  assign fire       = out_valid & out_ready;
  assign in_ready   = ~out_valid | (fire & final_beat);

  always_ff @(posedge clk) begin
    if (rst) begin
      elem_pend <= 1'b0;
      sum_pend  <= 1'b0;
      sum_sel   <= SEL_CONCAT;
    end else if (accept) begin
      elem_pend <= bundle.elem_valid;
      sum_pend  <= bundle.sum_valid;
      sum_sel   <= SEL_CONCAT;
    end else if (fire) begin
      if (elem_pend) begin
        elem_pend <= 1'b0;
      end else begin
        case (sum_sel)
          SEL_CONCAT: sum_sel  <= SEL_PORT;
          SEL_PORT:   sum_sel  <= SEL_LANG;
          default:    sum_pend <= 1'b0;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      elem <= bundle.elem;
      summ <= bundle.summ;
    end
  end

  always_comb begin
    beat = '0;
    if (elem_pend) begin
      beat.kind     = elem.kind;
      beat.id       = elem.id;
      beat.val_a    = elem.val_a;
      beat.val_b    = elem.val_b;
      beat.elem_end = elem.elem_end;
    end else begin
      beat.trunc = summ.trunc;
      case (sum_sel)
        SEL_CONCAT: begin
          beat.kind    = KIND_CONCAT;
          beat.val_a   = summ.concat_ref;
          beat.val_b   = {8'd0, summ.concat_total};
          beat.val_c   = summ.concat_seq;
          beat.present = summ.concat_ok;
          beat.wide    = summ.concat_wide;
        end
        SEL_PORT: begin
          beat.kind    = KIND_PORT;
          beat.val_a   = summ.dest_port;
          beat.val_b   = summ.orig_port;
          beat.present = summ.port_ok;
          beat.wide    = summ.port_wide;
        end
        default: begin
          beat.kind  = KIND_LANG;
          beat.val_a = {8'd0, summ.single_shift};
          beat.val_b = {8'd0, summ.locking_shift};
          beat.last  = 1'b1;
        end
      endcase
    end
  end

endmodule

// ----- src/sms_udh_element_parser.sv -----
// channel  dir  tdata                      tuser         tlast
// s_axis   in   [7:0] hdr_byte             -             hdr_last
// m_axis   out  [7:0] elt_id, [23:8] a,    [2:0] kind    last_result
//               [39:24] b, [47:40] c, [48] present, [49] wide,
//               [50] element_end, [51] truncated, [55:52] zero
//
// One header byte is taken per cycle while s_tready is high; a byte with a result
// shows it on the next cycle from the output register.
// The final byte of a header yields up to four beats, so s_tready stays low
// while the summaries drain from the output register.
// Reset (rst, synchronous) returns the parser to expect an identifier and
// clears all kept elements; results still pending are dropped.
// A stall on m_tready holds the current beat and backs up into s_tready.
module sms_udh_element_parser
  import sudh_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,   // [7:0] hdr_byte
  input  logic        s_tlast,
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [55:0] m_tdata,   // elt_id, value_a, value_b, value_c, present, wide,
                                 // element_end, truncated, zero fill
  output logic [2:0]  m_tuser,   // [2:0] out_kind
  output logic        m_tlast
);

  logic    accept;
  bundle_t bundle;
  beat_t   beat;

  assign accept = s_tvalid & s_tready;

  sudh_core u_core (
    .clk      (clk),
    .rst      (rst),
    .accept   (accept),
    .hdr_byte (s_tdata),
    .hdr_last (s_tlast),
    .bundle   (bundle)
  );

  sudh_emit u_emit (
    .clk       (clk),
    .rst       (rst),
    .accept    (accept),
    .bundle    (bundle),
    .in_ready  (s_tready),
    .out_valid (m_tvalid),
    .out_ready (m_tready),
    .beat      (beat)
  );

  assign m_tdata = {4'd0, beat.trunc, beat.elem_end, beat.wide, beat.present,
                    beat.val_c, beat.val_b, beat.val_a, beat.id};
  assign m_tuser = beat.kind;
  assign m_tlast = beat.last;

endmodule

// ----- src/sudh_checker.sv -----
`include "sms_udh_element_parser_macros.svh"

module sudh_checker
  import sudh_pkg::*;
(
  input logic        clk,
  input logic        rst,
  input logic        s_tvalid,
  input logic        s_tready,
  input logic        s_tlast,
  input logic        m_tvalid,
  input logic        m_tready,
  input logic [55:0] m_tdata,
  input logic [2:0]  m_tuser,
  input logic        m_tlast
);

  logic in_beat;
  logic out_beat;

  assign in_beat  = s_tvalid & s_tready;
  assign out_beat = m_tvalid & m_tready;

  `SUDH_ASSERT_SAME(a_last_is_lang, clk, rst, m_tvalid && m_tlast, m_tuser == KIND_LANG)
  `SUDH_ASSERT_NEXT(a_concat_then_port, clk, rst, out_beat && m_tuser == KIND_CONCAT, m_tvalid && m_tuser == KIND_PORT)
  `SUDH_ASSERT_NEXT(a_final_byte_stalls, clk, rst, in_beat && s_tlast, m_tvalid && !s_tready)
  `SUDH_ASSERT_NEXT(a_stall_holds, clk, rst, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata) && $stable(m_tuser))

endmodule

bind sms_udh_element_parser sudh_checker u_sudh_checker (.*);

// ----- bench/tb_top.sv -----
`timescale 1ns / 1ps

module tb_top;
  import sudh_pkg::*;

  localparam logic [7:0] ID_CONCAT8  = 8'h00;
  localparam logic [7:0] ID_SPECIAL  = 8'h01;
  localparam logic [7:0] ID_PORT8    = 8'h04;
  localparam logic [7:0] ID_PORT16   = 8'h05;
  localparam logic [7:0] ID_CONCAT16 = 8'h08;
  localparam logic [7:0] ID_SSHIFT   = 8'h24;
  localparam logic [7:0] ID_LSHIFT   = 8'h25;

  localparam int HDR_BYTES   = 430;
  localparam int CALM_TAIL   = 40;
  localparam int CYCLE_LIMIT = 300000;

  typedef enum logic [1:0] {PH_ID, PH_LEN, PH_FIXED, PH_MISC} parse_ph_t;

  typedef struct {
    logic [7:0] hbyte;
    logic       fin;
    bit         hold_back;
  } hdr_item_t;

  logic        clk;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [7:0]  s_tdata = 8'h00;   // [7:0] hdr_byte
  logic        s_tlast = 1'b0;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [55:0] m_tdata;           // [7:0] elt_id, [23:8] value_a, [39:24] value_b,
                                  // [47:40] value_c, [48] present, [49] wide,
                                  // [50] element_end, [51] truncated, [55:52] zero
  logic [2:0]  m_tuser;           // [2:0] out_kind
  logic        m_tlast;

  sms_udh_element_parser dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tlast  (s_tlast),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
  );

  hdr_item_t  hdr_q[$];
  beat_t      beats_due[$];
  logic [7:0] build_q[$];
  int         last_start;

  int  cycles = 0;
  int  errors = 0;
  int  beats_checked = 0;
  int  n_hdrs = 0;
  int  n_cut = 0;
  int  n_bytes = 0;
  int  s_gap = 0;
  int  r_gap = 0;
  bit  in_took = 0;

  parse_ph_t   ph;
  logic [7:0]  cur_id, remain, idx;
  logic [15:0] sc1, sc2;
  logic [7:0]  sc3;
  logic        concat_ok, concat_wide, port_ok, port_wide;
  logic [15:0] concat_ref, dest_port, orig_port;
  logic [7:0]  concat_total, concat_seq, s_shift, l_shift;

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  function automatic logic [7:0] fixed_len(logic [7:0] id);
    case (id)
      ID_CONCAT8:  return 8'd3;
      ID_CONCAT16: return 8'd4;
      ID_PORT8:    return 8'd2;
      ID_PORT16:   return 8'd4;
      ID_SPECIAL:  return 8'd2;
      ID_SSHIFT:   return 8'd1;
      ID_LSHIFT:   return 8'd1;
      default:     return 8'd0;
    endcase
  endfunction

  function automatic beat_t mk_beat(kind_t k, logic [7:0] id, logic [15:0] a, logic [15:0] b,
                                    logic [7:0] c, logic p, logic w, logic e, logic t,
                                    logic l);
    beat_t r;
    r.kind = k;
    r.id = id;
    r.val_a = a;
    r.val_b = b;
    r.val_c = c;
    r.present = p;
    r.wide = w;
    r.elem_end = e;
    r.trunc = t;
    r.last = l;
    return r;
  endfunction

  function automatic bit idle_ok();
    return hdr_q.size() >= CALM_TAIL && (cycles / 128) % 3 != 0;
  endfunction

  task automatic clear_parser();
    ph = PH_ID;
    cur_id = 0; remain = 0; idx = 0;
    sc1 = 0; sc2 = 0; sc3 = 0;
    concat_ok = 0; concat_wide = 0; concat_ref = 0; concat_total = 0; concat_seq = 0;
    port_ok = 0; port_wide = 0; dest_port = 0; orig_port = 0;
    s_shift = 0; l_shift = 0;
  endtask

  task automatic keep_concat(input logic w);
    if (sc2 != 0 && sc3 != 0 && {8'h00, sc3} <= sc2) begin
      concat_ok = 1'b1;
      concat_wide = w;
      concat_ref = sc1;
      concat_total = sc2[7:0];
      concat_seq = sc3;
    end
  endtask

  task automatic parse_udh_byte(input logic [7:0] b, input logic fin);
    logic tr;
    case (ph)
      PH_ID: begin
        cur_id = b;
        ph = PH_LEN;
      end
      PH_LEN: begin
        idx = 0; sc1 = 0; sc2 = 0; sc3 = 0;
        if (fixed_len(cur_id) != 0) begin
          remain = fixed_len(cur_id);
          ph = PH_FIXED;
        end else if (b == 0) begin
          beats_due.push_back(mk_beat(KIND_EMPTY, cur_id, 0, 0, 0, 0, 0, 0, 0, 0));
          ph = PH_ID;
        end else begin
          remain = b;
          ph = PH_MISC;
        end
      end
      PH_FIXED: begin
        case (cur_id)
          ID_CONCAT8: begin
            if (idx == 0) sc1 = {8'h00, b};
            else if (idx == 1) sc2 = {8'h00, b};
            else begin
              sc3 = b;
              keep_concat(1'b0);
            end
          end
          ID_CONCAT16: begin
            if (idx == 0) sc1 = {b, 8'h00};
            else if (idx == 1) sc1 = sc1 | {8'h00, b};
            else if (idx == 2) sc2 = {8'h00, b};
            else begin
              sc3 = b;
              keep_concat(1'b1);
            end
          end
          ID_PORT8: begin
            if (idx == 0) sc1 = {8'h00, b};
            else begin
              port_ok = 1'b1;
              port_wide = 1'b0;
              dest_port = {8'h00, sc1[7:0]};
              orig_port = {8'h00, b};
            end
          end
          ID_PORT16: begin
            if (idx == 0) sc1 = {b, 8'h00};
            else if (idx == 1) sc1 = sc1 | {8'h00, b};
            else if (idx == 2) sc2 = {b, 8'h00};
            else begin
              port_ok = 1'b1;
              port_wide = 1'b1;
              dest_port = sc1;
              orig_port = sc2 | {8'h00, b};
            end
          end
          ID_SPECIAL: begin
            if (idx == 0) sc1 = {8'h00, b};
            else beats_due.push_back(mk_beat(KIND_SPECIAL, cur_id, sc1, {8'h00, b},
                                             0, 0, 0, 0, 0, 0));
          end
          ID_SSHIFT: s_shift = b;
          default: l_shift = b;
        endcase
        idx = idx + 1;
        remain = remain - 1;
        if (remain == 0) ph = PH_ID;
      end
      default: begin
        remain = remain - 1;
        beats_due.push_back(mk_beat(KIND_MISC, cur_id, {8'h00, b}, {8'h00, idx}, 0, 0, 0,
                                    remain == 0, 0, 0));
        idx = idx + 1;
        if (remain == 0) ph = PH_ID;
      end
    endcase
    if (fin) begin
      tr = (ph != PH_ID);
      beats_due.push_back(mk_beat(KIND_CONCAT, 0, concat_ref, {8'h00, concat_total},
                                  concat_seq, concat_ok, concat_wide, 0, tr, 0));
      beats_due.push_back(mk_beat(KIND_PORT, 0, dest_port, orig_port, 0, port_ok,
                                  port_wide, 0, tr, 0));
      beats_due.push_back(mk_beat(KIND_LANG, 0, {8'h00, s_shift}, {8'h00, l_shift}, 0, 0,
                                  0, 0, tr, 1));
      clear_parser();
    end
  endtask

  task automatic check_field(input string name, input int unsigned e, input int unsigned a);
    if (e != a) begin
      $error("%s: expected %0h, got %0h", name, e, a);
      errors++;
    end
  endtask

  function automatic logic [7:0] len_byte(logic [7:0] n);
    if ($urandom_range(0, 4) == 0) return 8'($urandom_range(0, 255));
    return n;
  endfunction

  task automatic add_element(input int sel);
    logic [7:0] cnt, seq, id, len;
    cnt = 8'($urandom_range(1, 255));
    seq = 8'($urandom_range(1, cnt));
    if ($urandom_range(0, 3) == 0) begin
      cnt = 8'($urandom_range(0, 3));
      seq = 8'($urandom_range(0, 5));
    end
    last_start = build_q.size();
    case (sel)
      0: begin
        build_q.push_back(ID_CONCAT8);
        build_q.push_back(len_byte(8'd3));
        build_q.push_back(8'($urandom_range(0, 255)));
        build_q.push_back(cnt);
        build_q.push_back(seq);
      end
      1: begin
        build_q.push_back(ID_CONCAT16);
        build_q.push_back(len_byte(8'd4));
        build_q.push_back(8'($urandom_range(0, 255)));
        build_q.push_back(8'($urandom_range(0, 255)));
        build_q.push_back(cnt);
        build_q.push_back(seq);
      end
      2: begin
        build_q.push_back(ID_PORT8);
        build_q.push_back(len_byte(8'd2));
        repeat (2) build_q.push_back(8'($urandom_range(0, 255)));
      end
      3: begin
        build_q.push_back(ID_PORT16);
        build_q.push_back(len_byte(8'd4));
        repeat (4) build_q.push_back(8'($urandom_range(0, 255)));
      end
      4: begin
        build_q.push_back(ID_SPECIAL);
        build_q.push_back(len_byte(8'd2));
        repeat (2) build_q.push_back(8'($urandom_range(0, 255)));
      end
      5, 6: begin
        build_q.push_back(sel == 5 ? ID_SSHIFT : ID_LSHIFT);
        build_q.push_back(len_byte(8'd1));
        build_q.push_back(8'($urandom_range(0, 255)));
      end
      7, 8: begin
        do id = 8'($urandom_range(0, 255)); while (fixed_len(id) != 0);
        len = ($urandom_range(0, 7) == 0) ? 8'($urandom_range(0, 24))
                                          : 8'($urandom_range(0, 6));
        build_q.push_back(id);
        build_q.push_back(len);
        repeat (len) build_q.push_back(8'($urandom_range(0, 255)));
      end
      default: repeat ($urandom_range(1, 6)) build_q.push_back(8'($urandom_range(0, 255)));
    endcase
  endtask

  task automatic flush_header(input bit drain);
    for (int i = 0; i < build_q.size(); i++)
      hdr_q.push_back('{hbyte: build_q[i], fin: (i == build_q.size() - 1),
                        hold_back: (drain && i == 0)});
    n_bytes += build_q.size();
    n_hdrs++;
    build_q.delete();
  endtask

  task automatic add_header(input bit drain);
    int n;
    n = $urandom_range(1, 5);
    repeat (n) add_element($urandom_range(0, 9));
    if ($urandom_range(0, 6) == 0 && build_q.size() - last_start >= 2) begin
      repeat ($urandom_range(1, build_q.size() - last_start - 1)) void'(build_q.pop_back());
      n_cut++;
    end
    flush_header(drain);
  endtask

  // input side
  always @(negedge clk) begin
    hdr_item_t it;
    logic nv;
    nv = s_tvalid;
    if (rst) begin
      nv = 1'b0;
    end else if (!s_tvalid || in_took) begin
      nv = 1'b0;
      if (s_gap > 0) begin
        s_gap--;
      end else if (idle_ok() && $urandom_range(0, 9) == 0) begin
        s_gap = $urandom_range(0, 9);
      end else if (hdr_q.size() != 0 && !(hdr_q[0].hold_back && beats_due.size() != 0)) begin
        it = hdr_q.pop_front();
        s_tdata <= it.hbyte;
        s_tlast <= it.fin;
        nv = 1'b1;
      end
    end
    s_tvalid <= nv;
  end

  // output side backpressure
  always @(negedge clk) begin
    if (rst) begin
      m_tready <= 1'b0;
    end else if (r_gap > 0) begin
      r_gap--;
      m_tready <= 1'b0;
    end else if (idle_ok() && $urandom_range(0, 7) == 0) begin
      r_gap = $urandom_range(0, 9);
      m_tready <= 1'b0;
    end else begin
      m_tready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    beat_t got, want;
    in_took = 0;
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("simulation failed");
      $finish;
    end else if (!rst) begin
      if (m_tvalid && m_tready) begin
        got = mk_beat(kind_t'(m_tuser), m_tdata[7:0], m_tdata[23:8], m_tdata[39:24],
                      m_tdata[47:40], m_tdata[48], m_tdata[49], m_tdata[50], m_tdata[51],
                      m_tlast);
        beats_checked++;
        if (beats_due.size() == 0) begin
          $error("unexpected beat: kind %0d id %0h", got.kind, got.id);
          errors++;
        end else begin
          want = beats_due.pop_front();
          check_field("out_kind", want.kind, got.kind);
          check_field("elt_id", want.id, got.id);
          check_field("value_a", want.val_a, got.val_a);
          check_field("value_b", want.val_b, got.val_b);
          check_field("value_c", want.val_c, got.val_c);
          check_field("present", want.present, got.present);
          check_field("wide", want.wide, got.wide);
          check_field("element_end", want.elem_end, got.elem_end);
          check_field("truncated", want.trunc, got.trunc);
          check_field("last_result", want.last, got.last);
        end
      end
      if (s_tvalid && s_tready) begin
        in_took = 1;
        parse_udh_byte(s_tdata, s_tlast);
      end
    end
  end

  initial begin
    clear_parser();

    // empty misc, then a 16-bit concat cut off after one value byte
    build_q = '{8'h7F, 8'h00, ID_CONCAT16, 8'h04, 8'h12};
    flush_header(1'b0);
    n_cut++;
    // all fixed-count elements but the 16-bit ones, lengths ignored, byte extremes
    build_q = '{ID_CONCAT8, 8'h00, 8'hFF, 8'h03, 8'h02,
                ID_SPECIAL, 8'h02, 8'hC1, 8'h7E,
                ID_SSHIFT, 8'h01, 8'hFF,
                ID_LSHIFT, 8'h01, 8'h00,
                ID_PORT8, 8'h09, 8'h80, 8'h01,
                8'hFF, 8'h01, 8'h00};
    flush_header(1'b1);

    while (n_bytes < HDR_BYTES) add_header(n_hdrs % 9 == 2);

    repeat (6) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    while (hdr_q.size() != 0 || s_tvalid) @(posedge clk);
    while (beats_due.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);

    $display("%0d header bytes in %0d headers (%0d cut short) sent with random stalls",
             n_bytes, n_hdrs, n_cut);
    $display("%0d result beats compared against the predicted element stream", beats_checked);
    if (errors == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

// ----- files.f -----
+incdir+src
src/sudh_pkg.sv
src/sudh_core.sv
src/sudh_emit.sv
src/sms_udh_element_parser.sv
src/sudh_checker.sv
bench/tb_top.sv
